>>> rtl/core/rstk_pkg.sv
// Shared types and constants for the resizing stack tracker.
package rstk_pkg;

  localparam int unsigned CapWidth  = 12;
  localparam int unsigned RegWidth  = 11;
  localparam int unsigned OutWidth  = 32;
  localparam int unsigned CfgIdxW   = 2;

  localparam logic [CapWidth-1:0] CapMax   = 12'hFFF;
  localparam logic [CapWidth-1:0] CapReset = 12'd10;
  localparam logic [RegWidth-1:0] MinReset = 11'd10;

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_IDX_INIT_CAP = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_IDX_MIN_CAP  = 2'd1;

  // Controller to datapath
  typedef struct packed {
    logic accept;   // input word taken this edge
    logic capture;  // store read data is valid, latch popped word
  } rstk_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic empty;    // no words held
  } rstk_stat_t;

endpackage

>>> rtl/core/resizing_stack_tracker_core.sv
// Top level of the resizing stack tracker: controller, datapath and ports.
// A LIFO stack of signed words kept in a single-port RAM of STORE_DEPTH
// entries, with a tracker of the logical capacity of a growable array
// alongside it. A push that finds the count equal to the capacity doubles
// the capacity (saturating at 4095) and raises the peak; a pop on a
// non-empty stack first halves the capacity when it differs from the
// minimum and the count is at most half of it. An empty pop answers -1 with
// status 1; a push into a full store is refused with status 2 and changes
// nothing. Timing: a push, an empty pop and a refused push show the result
// word in the cycle after acceptance; a reading pop goes through the
// registered RAM read and the result register, and input stalls until
// its result is registered. Pushes stream one a cycle unless output stalls.
// One result register sits on the output; a new word is taken while the
// previous result leaves in the same cycle. Configuration writes (index 0:
// initial capacity, also loaded into the current capacity at once; index 1:
// minimum capacity; other indices ignored) are always ready and must only
// be issued while the block is idle. The store needs no clearing after
// reset: a pop only ever reads entries that an earlier push wrote.
module resizing_stack_tracker_core import rstk_pkg::*; #(
  parameter int unsigned STORE_DEPTH = 1024,
  parameter int unsigned WORD_WIDTH  = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input words
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                kind_i,
  input  logic signed [31:0]  push_value_i,
  // result words
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [31:0]  pop_value_o,
  output logic [1:0]          status_o,
  output logic [CapWidth-1:0] current_capacity_o,
  output logic [CapWidth-1:0] peak_capacity_o,
  output logic [RegWidth-1:0] item_count_o,
  // configuration writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [RegWidth-1:0] cfg_data_i
);

  rstk_cmd_t  cmd;
  rstk_stat_t stat;

  assign cfg_ready_o = 1'b1;

  rstk_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  rstk_datapath #(
    .STORE_DEPTH (STORE_DEPTH),
    .WORD_WIDTH  (WORD_WIDTH)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .kind_i             (kind_i),
    .push_value_i       (push_value_i),
    .cfg_we_i           (cfg_valid_i && cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .pop_value_o        (pop_value_o),
    .status_o           (status_o),
    .current_capacity_o (current_capacity_o),
    .peak_capacity_o    (peak_capacity_o),
    .item_count_o       (item_count_o)
  );

endmodule

>>> rtl/core/rstk_ram.sv
// Generic single-port RAM with registered read data.
module rstk_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/rstk_ctrl.sv
// Handshake and sequencing controller for the resizing stack tracker.
module rstk_ctrl import rstk_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       kind_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output rstk_cmd_t  cmd_o,
  input  rstk_stat_t stat_i
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   needs_read;

  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign needs_read = (kind_i == KIND_POP) && !stat_i.empty;

  always_comb begin
    state_d       = state_q;
    cmd_o.accept  = 1'b0;
    cmd_o.capture = 1'b0;
    out_valid_d   = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.accept = 1'b1;
          if (needs_read) begin
            state_d = ST_READ;
          end else begin
            out_valid_d = 1'b1;
          end
        end
      end
      ST_READ: begin
        cmd_o.capture = 1'b1;
        out_valid_d   = 1'b1;
        state_d       = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/core/rstk_datapath.sv
// Stack store, count and capacity tracking for the resizing stack tracker.
module rstk_datapath import rstk_pkg::*; #(
  parameter int unsigned STORE_DEPTH = 1024,
  parameter int unsigned WORD_WIDTH  = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rstk_cmd_t            cmd_i,
  output rstk_stat_t           stat_o,
  input  logic                 kind_i,
  input  logic signed [31:0]   push_value_i,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [RegWidth-1:0]  cfg_data_i,
  output logic signed [31:0]   pop_value_o,
  output logic [1:0]           status_o,
  output logic [CapWidth-1:0]  current_capacity_o,
  output logic [CapWidth-1:0]  peak_capacity_o,
  output logic [RegWidth-1:0]  item_count_o
);

  localparam int unsigned AW   = $clog2(STORE_DEPTH);
  localparam int unsigned CW   = $clog2(STORE_DEPTH + 1);
  localparam int unsigned CMPW = (CW > CapWidth) ? CW : CapWidth;

  logic [CW-1:0]       count_q, count_d;
  logic [CapWidth-1:0] cap_q, cap_d;
  logic [CapWidth-1:0] peak_q, peak_d;
  logic [RegWidth-1:0] min_q;
  logic [31:0]         pop_value_q;
  logic [1:0]          status_q, status_d;

  logic [CW-1:0]       count_dec;
  logic [CMPW-1:0]     count_ext, cap_ext, half_ext;
  logic                full, empty;
  logic [CapWidth:0]   cap_dbl;
  logic [CapWidth-1:0] cap_dbl_sat;
  logic                is_push;
  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_addr;
  logic [63:0]         wdata_wide;
  logic [WORD_WIDTH-1:0] ram_rdata;
  logic [63:0]         rdata_ext;

  assign count_dec = count_q - CW'(1);
  assign count_ext = CMPW'(count_q);
  assign cap_ext   = CMPW'(cap_q);
  assign half_ext  = CMPW'(cap_q >> 1);
  assign full      = (count_q == CW'(STORE_DEPTH));
  assign empty     = (count_q == '0);
  assign is_push   = (kind_i == KIND_PUSH);

  // Doubling saturates at the top of the 12-bit capacity range
  assign cap_dbl     = {cap_q, 1'b0};
  assign cap_dbl_sat = cap_dbl[CapWidth] ? CapMax : cap_dbl[CapWidth-1:0];

  always_comb begin
    count_d  = count_q;
    cap_d    = cap_q;
    peak_d   = peak_q;
    status_d = status_q;
    if (cmd_i.accept) begin
      status_d = STATUS_OK;
      if (is_push) begin
        if (full) begin
          status_d = STATUS_FULL;
        end else begin
          if (count_ext == cap_ext) begin
            cap_d = cap_dbl_sat;
            if (peak_q < cap_dbl_sat) begin
              peak_d = cap_dbl_sat;
            end
          end
          count_d = count_q + CW'(1);
        end
      end else begin
        if (empty) begin
          status_d = STATUS_EMPTY;
        end else begin
          if ((cap_q != CapWidth'(min_q)) && (count_ext <= half_ext)) begin
            cap_d = cap_q >> 1;
          end
          count_d = count_dec;
        end
      end
    end
  end

  assign ram_we     = cmd_i.accept && is_push && !full;
  assign ram_re     = cmd_i.accept && !is_push && !empty;
  assign ram_addr   = is_push ? count_q[AW-1:0] : count_dec[AW-1:0];
  assign wdata_wide = {32'b0, push_value_i};

  rstk_ram #(
    .WIDTH (WORD_WIDTH),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (wdata_wide[WORD_WIDTH-1:0]),
    .rdata_o (ram_rdata)
  );

  // Sign-extend the stored word, keep the low 32 bits
  assign rdata_ext = 64'($signed(ram_rdata));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      cap_q   <= CapReset;
      peak_q  <= '0;
      min_q   <= MinReset;
    end else begin
      count_q <= count_d;
      peak_q  <= peak_d;
      if (cfg_we_i && (cfg_index_i == CFG_IDX_INIT_CAP)) begin
        cap_q <= CapWidth'(cfg_data_i);
      end else begin
        cap_q <= cap_d;
      end
      if (cfg_we_i && (cfg_index_i == CFG_IDX_MIN_CAP)) begin
        min_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    if (cmd_i.accept) begin
      pop_value_q <= (!is_push && empty) ? '1 : '0;
    end else if (cmd_i.capture) begin
      pop_value_q <= rdata_ext[31:0];
    end
  end

  assign stat_o.empty       = empty;
  assign pop_value_o        = pop_value_q;
  assign status_o           = status_q;
  assign current_capacity_o = cap_q;
  assign peak_capacity_o    = peak_q;
  assign item_count_o       = count_ext[RegWidth-1:0];

endmodule
